/* rtl/ptpt_pkg.sv */
// shared types and constants for the periodic task poll table
`timescale 1ns / 1ps

package ptpt_pkg;

	localparam int SLOT_COUNT    = 16;
	localparam int NUM_TASKS_DEF = 16;
	localparam int SLOT_W        = 4;
	localparam int TIME_W        = 32;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_POLL   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_POLL  = 2'd1,
		ST_FLUSH = 2'd2
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_ADD    = 3'd1,
		CELL_REMOVE = 3'd2,
		CELL_CLEAR  = 3'd3,
		CELL_ROTATE = 3'd4
	} cell_mode_t;

	// one run-order position
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] last_run;
	} cell_data_t;

	// command broadcast to every cell
	typedef struct packed {
		cell_mode_t        mode;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] period;
		logic              append_ok;
	} cell_ctl_t;

endpackage

/* rtl/periodic_task_poll_table.sv */
// top level of the periodic task poll table: command decode, poll walk and result register
`timescale 1ns / 1ps

//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------------
//  command  | in        | start high while busy low    | req_type, task_slot, period, now
//  result   | out       | result_stb, one cycle each   | fired_slot, last
//
// add, remove and clear take effect at the accepting edge and never raise busy
// a poll keeps busy high for CAP rotations of the cell chain
//   through the head cell, then a flush state that releases the held final result
// the last result of a poll is strobed in the first cycle with busy low
// arst_n clears the chain's valid bits, the walk state and the result strobe
// results cannot be stalled; every strobe is one complete transaction

module periodic_task_poll_table #(
	parameter int NUM_TASKS = ptpt_pkg::NUM_TASKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [ptpt_pkg::SLOT_W-1:0]   task_slot,
	input  logic [ptpt_pkg::TIME_W-1:0]   period,
	input  logic [ptpt_pkg::TIME_W-1:0]   now,
	output logic                          result_stb,
	output logic [ptpt_pkg::SLOT_W-1:0]   fired_slot,
	output logic                          last
);
	import ptpt_pkg::*;

	// tasks the table can hold; slots at or above this are ignored
	localparam int CAP   = (NUM_TASKS < SLOT_COUNT) ? NUM_TASKS : SLOT_COUNT;
	localparam int CNT_W = $clog2(CAP + 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] now_q;
	logic              pend_valid_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic              result_stb_q;
	logic [SLOT_W-1:0] fired_slot_q;
	logic              last_q;

	cell_ctl_t         ctl;
	cell_data_t        cells [CAP];
	cell_data_t        nbrs  [CAP];
	cell_data_t        wrap;
	cell_data_t        head;
	logic [CAP-1:0]    match;
	logic [CAP:0]      shift;
	logic              accept;
	logic              slot_ok;
	logic [TIME_W-1:0] elapsed;
	logic              head_due;
	logic              walk_end;
	logic              emit;
	logic [SLOT_W-1:0] emit_slot;
	logic              emit_last;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign slot_ok = ({1'b0, task_slot} < (SLOT_W + 1)'(CAP));

	// the head cell is the task under test during the walk
	assign head     = cells[0];
	assign elapsed  = now_q - head.last_run;
	assign head_due = head.valid && (elapsed >= head.period);
	assign walk_end = (cnt_q == CNT_W'(CAP - 1));

	// head goes round to the tail, stamped with the poll time when it fires
	always_comb begin
		wrap = head;
		if (head_due) begin
			wrap.last_run = now_q;
		end
	end

	// state machine: command decode, walk control and result selection
	always_comb begin
		state_d       = state_q;
		ctl.mode      = CELL_HOLD;
		ctl.slot      = task_slot;
		ctl.period    = period;
		ctl.append_ok = slot_ok && !(|match);
		emit          = 1'b0;
		emit_slot     = pend_slot_q;
		emit_last     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_ADD:    ctl.mode = CELL_ADD;
						REQ_REMOVE: ctl.mode = CELL_REMOVE;
						REQ_CLEAR:  ctl.mode = CELL_CLEAR;
						default:    state_d  = ST_POLL;
					endcase
				end
			end
			ST_POLL: begin
				ctl.mode = CELL_ROTATE;
				// a held result goes out once a later task proves it is not the last
				emit = head_due && pend_valid_q;
				if (walk_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				emit      = pend_valid_q;
				emit_last = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// chain wiring: each cell takes from its right neighbor, the tail from the head
	assign shift[0] = 1'b0;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		if (i < CAP - 1) begin : g_mid
			assign nbrs[i] = cells[i+1];
		end else begin : g_tail
			assign nbrs[i] = (ctl.mode == CELL_ROTATE) ? wrap : cell_data_t'('0);
		end

		ptpt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.nbr        (nbrs[i]),
			.prev_valid ((i == 0) ? 1'b1 : cells[(i == 0) ? 0 : i-1].valid),
			.shift_in   (shift[i]),
			.data       (cells[i]),
			.match      (match[i]),
			.shift_out  (shift[i+1])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			result_stb_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_stb_q <= emit;
			if (state_q == ST_POLL) begin
				cnt_q <= walk_end ? '0 : cnt_q + CNT_W'(1);
				if (head_due) begin
					pend_valid_q <= 1'b1;
				end
			end else if (state_q == ST_FLUSH) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= now;
		end
		if ((state_q == ST_POLL) && head_due) begin
			pend_slot_q <= head.slot;
		end
		if (emit) begin
			fired_slot_q <= emit_slot;
			last_q       <= emit_last;
		end
	end

	assign result_stb = result_stb_q;
	assign fired_slot = fired_slot_q;
	assign last       = last_q;

endmodule

/* rtl/ptpt_cell.sv */
// one cell of the run-order chain: holds one task and shifts toward the head
`timescale 1ns / 1ps

module ptpt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptpt_pkg::cell_ctl_t   ctl,
	input  ptpt_pkg::cell_data_t  nbr,
	input  logic                  prev_valid,
	input  logic                  shift_in,
	output ptpt_pkg::cell_data_t  data,
	output logic                  match,
	output logic                  shift_out
);
	import ptpt_pkg::*;

	logic              valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] last_run_q;
	logic              take_nbr;
	logic              append;

	assign data      = '{valid: valid_q, slot: slot_q, period: period_q, last_run: last_run_q};
	assign match     = valid_q && (slot_q == ctl.slot);
	assign shift_out = shift_in | match;

	// first free cell takes a new task
	assign append   = (ctl.mode == CELL_ADD) && ctl.append_ok && !valid_q && prev_valid;
	assign take_nbr = (ctl.mode == CELL_ROTATE) || ((ctl.mode == CELL_REMOVE) && shift_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (ctl.mode == CELL_CLEAR) begin
				valid_q <= 1'b0;
			end else if (take_nbr) begin
				valid_q <= nbr.valid;
			end else if (append) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_nbr) begin
			slot_q     <= nbr.slot;
			period_q   <= nbr.period;
			last_run_q <= nbr.last_run;
		end else if (append) begin
			slot_q     <= ctl.slot;
			period_q   <= ctl.period;
			last_run_q <= '0;
		end else if ((ctl.mode == CELL_ADD) && match) begin
			// re-add of an active task keeps its place
			period_q   <= ctl.period;
			last_run_q <= '0;
		end
	end

endmodule

/* rtl/ptpt_checker.sv */
// port-level checks for the periodic task poll table and their binding
`timescale 1ns / 1ps

module ptpt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] req_type,
	input logic       result_stb,
	input logic       last
);
	import ptpt_pkg::*;

	// results only come out of a poll walk
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb |-> $past(busy))
		else $error("result without a poll in progress");

	// a result that is not the last leaves the walk still running
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(result_stb && !last) |-> busy)
		else $error("non-final result after the poll ended");

	// an accepted poll raises busy
	a_poll_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_POLL)) |=> busy)
		else $error("poll accepted without busy");

	// table edits finish at the accepting edge
	a_edit_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type != REQ_POLL)) |=> !busy)
		else $error("table edit raised busy");

endmodule

bind periodic_task_poll_table ptpt_checker u_ptpt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.req_type   (req_type),
	.result_stb (result_stb),
	.last       (last)
);
